@@ design/srtf_pkg.sv @@
// Shared types and constants for the SRTF scheduler with dependency boost.
`timescale 1ns / 1ps
`default_nettype none
package srtf_pkg;

  localparam int ID_W            = 5;   // job id field width
  localparam int OP_W            = 2;
  localparam int LEN_FIELD_W     = 16;  // job_length field width
  localparam int ID_SPAN         = 32;  // ids reachable through the id field
  localparam int JOB_SLOTS_DEF   = 32;
  localparam int LENGTH_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_DEP    = 2'd1,
    OP_ARRIVE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_SCAN,
    ST_DECIDE,
    ST_RUN
  } state_e;

  // Candidate that travels down the cell chain during a minimum scan.
  typedef struct packed {
    logic            go;
    logic            vld;
    logic [ID_W-1:0] id;
  } cand_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic            load;
    logic            load_hold;
    logic            dep;
    logic            arrive;
    logic            retire;
    logic            dispatch;
    logic            requeue;
    logic            dec;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] tgt;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] best;
  } cmd_t;

endpackage
`default_nettype wire

@@ design/srtf_scheduler_with_dependency_boost_core.sv @@
// Top level of the SRTF scheduler: controller and the chain of job cells.
//
//  Channel  Dir  Beat contents
//  s_axis   in   tuser: op; tdata: job_id, job_length, target_id
//  m_axis   out  tuser: idle; tdata: running_job
//
// Load, dependency and arrival beats are absorbed as they are accepted.
// A tick beat passes through retire, scan, decide and result steps; the
// minimum search walks the candidate through one cell per cycle.
// The result register lets the next beat in while a result waits; a tick
// holds in its last step until that register is free.
// Reset clears all job state at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module srtf_scheduler_with_dependency_boost_core
  import srtf_pkg::*;
#(
  parameter int JOB_SLOTS   = JOB_SLOTS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [4:0] job_id, [20:5] job_length, [25:21] target_id, [31:26] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [4:0] running_job, [7:5] zero
  output logic [7:0]       m_axis_tdata_o,
  // [0] idle
  output logic [0:0]       m_axis_tuser_o
);

  localparam int LW = LENGTH_BITS;

  state_e          state_q, state_d;
  logic            busy_q, busy_d;
  logic [ID_W-1:0] cur_q, cur_d;
  logic            launch_q;
  logic            best_vld_q;
  logic [ID_W-1:0] best_id_q;
  logic [LW-1:0]   best_rem_q;
  logic            out_vld_q;
  logic [ID_W-1:0] out_run_q;
  logic            out_idle_q;

  logic            in_fire, out_free, out_load, id_ok, tgt_ok, cur_hit, preempt;
  op_e             in_op;
  logic [ID_W-1:0] in_id, in_tgt;
  logic [LW-1:0]   in_len, cur_rem;
  cmd_t            cmd;

  cand_t           cand_w [JOB_SLOTS+1];
  logic [LW-1:0]   crem_w [JOB_SLOTS+1];
  logic [LW-1:0]   cur_rem_w [JOB_SLOTS];
  logic [JOB_SLOTS-1:0] is_cur_w, ready_w;

  assign in_op   = op_e'(s_axis_tuser_i);
  assign in_id   = s_axis_tdata_i[4:0];
  assign in_len  = LW'(s_axis_tdata_i[20:5]);
  assign in_tgt  = s_axis_tdata_i[25:21];
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign id_ok   = int'(in_id) < JOB_SLOTS;
  assign tgt_ok  = int'(in_tgt) < JOB_SLOTS;
  assign cur_hit = busy_q && (cur_q == in_id);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_vld_q || m_axis_tready_i;

  always_comb begin
    cur_rem = '0;
    for (int k = 0; k < JOB_SLOTS; k++) cur_rem = cur_rem | cur_rem_w[k];
  end

  assign preempt = (best_rem_q < cur_rem) || ((best_rem_q == cur_rem) && (best_id_q < cur_q));

  always_comb begin
    cmd           = '0;
    cmd.id        = in_id;
    cmd.tgt       = in_tgt;
    cmd.cur       = cur_q;
    cmd.best      = best_id_q;
    cmd.load      = in_fire && (in_op == OP_LOAD) && id_ok;
    cmd.load_hold = cur_hit;
    cmd.dep       = in_fire && (in_op == OP_DEP) && id_ok && tgt_ok;
    cmd.arrive    = in_fire && (in_op == OP_ARRIVE) && id_ok && !cur_hit;
    cmd.retire    = (state_q == ST_RETIRE) && busy_q && (cur_rem == '0);
    cmd.dispatch  = (state_q == ST_DECIDE) && best_vld_q && (!busy_q || preempt);
    cmd.requeue   = (state_q == ST_DECIDE) && best_vld_q && busy_q && preempt;
    cmd.dec       = (state_q == ST_RUN) && out_free && busy_q;
  end

  always_comb begin
    state_d  = state_q;
    busy_d   = busy_q;
    cur_d    = cur_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_TICK)) state_d = ST_RETIRE;
      end
      ST_RETIRE: begin
        if (cmd.retire) busy_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cand_w[JOB_SLOTS].go) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (cmd.dispatch) begin
          cur_d  = best_id_q;
          busy_d = 1'b1;
        end
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      cur_q     <= '0;
      launch_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      busy_q   <= busy_d;
      cur_q    <= cur_d;
      launch_q <= (state_q == ST_RETIRE);
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && cand_w[JOB_SLOTS].go) begin
      best_vld_q <= cand_w[JOB_SLOTS].vld;
      best_id_q  <= cand_w[JOB_SLOTS].id;
      best_rem_q <= crem_w[JOB_SLOTS];
    end
    if (out_load) begin
      out_run_q  <= busy_q ? cur_q : '0;
      out_idle_q <= !busy_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_run_q};
  assign m_axis_tuser_o  = out_idle_q;

  // An empty candidate enters the head of the chain once per tick.
  assign cand_w[0] = '{go: launch_q, vld: 1'b0, id: '0};
  assign crem_w[0] = '0;

  for (genvar k = 0; k < JOB_SLOTS; k++) begin : g_cell
    srtf_cell #(
      .SLOT (k),
      .LW   (LW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .len_i      (in_len),
      .cand_i     (cand_w[k]),
      .cand_rem_i (crem_w[k]),
      .cand_o     (cand_w[k+1]),
      .cand_rem_o (crem_w[k+1]),
      .cur_rem_o  (cur_rem_w[k]),
      .is_cur_o   (is_cur_w[k]),
      .ready_o    (ready_w[k])
    );
  end

  a_cur_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(is_cur_w))
    else $error("current job matches more than one slot");

  a_running_not_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && busy_q |-> ((ready_w & is_cur_w) == '0))
    else $error("running job is still marked ready");

  a_scan_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_w[JOB_SLOTS].go |-> (state_q == ST_SCAN))
    else $error("scan result arrived outside the scan step");

  a_result_from_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_RUN))
    else $error("result beat not produced by a tick");

  a_preempt_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.requeue |-> cmd.dispatch && busy_q)
    else $error("requeue without a running job");

endmodule
`default_nettype wire

@@ design/srtf_cell.sv @@
// One job slot: remaining time, flags, dependency column and one scan stage.
`timescale 1ns / 1ps
`default_nettype none
module srtf_cell
  import srtf_pkg::*;
#(
  parameter int SLOT = 0,
  parameter int LW   = LENGTH_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cmd_t          cmd_i,
  input  wire logic [LW-1:0] len_i,
  input  wire cand_t         cand_i,
  input  wire logic [LW-1:0] cand_rem_i,
  output cand_t              cand_o,
  output logic [LW-1:0]      cand_rem_o,
  output logic [LW-1:0]      cur_rem_o,
  output logic               is_cur_o,
  output logic               ready_o
);

  logic [LW-1:0]      rem_q, rem_d;
  logic               start_q, start_d;
  logic               ready_q, ready_d;
  logic [ID_SPAN-1:0] dep_q, dep_d;
  cand_t              cand_q, cand_d;
  logic [LW-1:0]      crem_q, crem_d;
  logic               hit_id, hit_tgt, hit_cur, hit_best, better;

  assign hit_id   = (SLOT == int'(cmd_i.id));
  assign hit_tgt  = (SLOT == int'(cmd_i.tgt));
  assign hit_cur  = (SLOT == int'(cmd_i.cur));
  assign hit_best = (SLOT == int'(cmd_i.best));

  always_comb begin
    rem_d   = rem_q;
    start_d = start_q;
    ready_d = ready_q;
    dep_d   = dep_q;
    if (cmd_i.load && hit_id) begin
      rem_d = len_i;
      if (!cmd_i.load_hold) start_d = 1'b0;
    end
    // The column holds the sources whose retirement boosts this job.
    if (cmd_i.dep && hit_tgt) dep_d[cmd_i.id] = 1'b1;
    if (cmd_i.arrive && hit_id) ready_d = 1'b1;
    if (cmd_i.retire && dep_q[cmd_i.cur] && !start_q) rem_d = rem_q - (rem_q >> 1);
    if (cmd_i.requeue && hit_cur) ready_d = 1'b1;
    if (cmd_i.dispatch && hit_best) begin
      ready_d = 1'b0;
      start_d = 1'b1;
    end
    if (cmd_i.dec && hit_cur && (rem_q != '0)) rem_d = rem_q - 1'b1;
  end

  // Slots are visited in rising id order, so a tie keeps the earlier candidate.
  assign better = ready_q && (!cand_i.vld || (rem_q < cand_rem_i));

  always_comb begin
    cand_d = cand_i;
    crem_d = cand_rem_i;
    if (better) begin
      cand_d.vld = 1'b1;
      cand_d.id  = ID_W'(SLOT);
      crem_d     = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      start_q <= 1'b0;
      ready_q <= 1'b0;
      dep_q   <= '0;
      cand_q  <= '0;
    end else begin
      rem_q   <= rem_d;
      start_q <= start_d;
      ready_q <= ready_d;
      dep_q   <= dep_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crem_q <= crem_d;
  end

  assign cand_o     = cand_q;
  assign cand_rem_o = crem_q;
  assign is_cur_o   = hit_cur;
  assign cur_rem_o  = hit_cur ? rem_q : '0;
  assign ready_o    = ready_q;

endmodule
`default_nettype wire

@@ tb/sv/srtf_scheduler_with_dependency_boost_core_tb.sv @@
// Testbench for the SRTF scheduler core: directed and random beats against a predictor.
`timescale 1ns / 1ps
module srtf_scheduler_with_dependency_boost_core_tb;
  import srtf_pkg::*;

  localparam int NJOBS = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  srtf_scheduler_with_dependency_boost_core dut (.*);

  typedef struct packed {
    logic       idle;
    logic [4:0] job;
  } tick_res_t;

  // Predictor state.
  logic [15:0]      rem_q [NJOBS];
  logic [NJOBS-1:0] started_q, ready_q;
  logic [NJOBS-1:0] deps_q [NJOBS];
  logic [4:0]       cur_q;
  logic             busy_q;

  tick_res_t expected_ticks [$];
  int  errors = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_gaps = 1'b1;
  int  hold_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic bit runs_before(input logic [4:0] a, input logic [4:0] b);
    if (rem_q[a] != rem_q[b]) return rem_q[a] < rem_q[b];
    return a < b;
  endfunction

  // Applies one beat to the predictor; a tick queues its result.
  task automatic predict_beat(input op_e op, input logic [4:0] id, input logic [15:0] len,
                              input logic [4:0] tgt);
    logic [4:0] best;
    bit found;
    tick_res_t res;
    best = '0;
    found = 1'b0;
    case (op)
      OP_LOAD: begin
        rem_q[id] = len;
        if (!(busy_q && cur_q == id)) started_q[id] = 1'b0;
      end
      OP_DEP: deps_q[id][tgt] = 1'b1;
      OP_ARRIVE: begin
        if (!(busy_q && cur_q == id)) ready_q[id] = 1'b1;
      end
      default: begin
        if (busy_q && rem_q[cur_q] == 0) begin
          for (int k = 0; k < NJOBS; k++)
            if (deps_q[cur_q][k] && !started_q[k])
              rem_q[k] = 16'(rem_q[k] - rem_q[k] / 2);
          busy_q = 1'b0;
        end
        for (int k = 0; k < NJOBS; k++)
          if (ready_q[k] && (!found || runs_before(5'(k), best))) begin
            best = 5'(k);
            found = 1'b1;
          end
        if (found && (!busy_q || runs_before(best, cur_q))) begin
          if (busy_q) ready_q[cur_q] = 1'b1;
          ready_q[best] = 1'b0;
          started_q[best] = 1'b1;
          cur_q = best;
          busy_q = 1'b1;
        end
        if (busy_q) begin
          if (rem_q[cur_q] != 0) rem_q[cur_q] = 16'(rem_q[cur_q] - 1);
          res = '{idle: 1'b0, job: cur_q};
        end else begin
          res = '{idle: 1'b1, job: 5'd0};
        end
        expected_ticks.push_back(res);
      end
    endcase
  endtask

  task automatic send_beat(input op_e op, input logic [4:0] id, input logic [15:0] len,
                           input logic [4:0] tgt);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {6'd0, tgt, len, id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_beat(op, id, len, tgt);
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic tick();
    send_beat(OP_TICK, 5'($urandom), 16'($urandom), 5'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_cycles--;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        m_axis_tready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Result checker.
  initial begin
    tick_res_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_ticks.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_r = expected_ticks.pop_front();
          if (m_axis_tuser_o[0] !== exp_r.idle)
            report($sformatf("idle %b, expected %b", m_axis_tuser_o[0], exp_r.idle));
          if (m_axis_tdata_o !== {3'd0, exp_r.job})
            report($sformatf("running_job %0d, expected %0d", m_axis_tdata_o, exp_r.job));
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(OP_TICK, 5'd0, 16'd0, 5'd0);           // idle tick after reset
    send_beat(OP_LOAD, 5'd31, 16'hFFFF, 5'd0);
    send_beat(OP_LOAD, 5'd0, 16'd0, 5'd31);          // zero length job
    send_beat(OP_LOAD, 5'd5, 16'd40, 5'd0);
    send_beat(OP_LOAD, 5'd6, 16'd3, 5'd0);
    send_beat(OP_DEP, 5'd0, 16'hFFFF, 5'd5);
    send_beat(OP_DEP, 5'd0, 16'd0, 5'd5);            // duplicate dependency
    send_beat(OP_DEP, 5'd6, 16'd0, 5'd6);            // self dependency
    send_beat(OP_DEP, 5'd6, 16'd0, 5'd31);
    send_beat(OP_ARRIVE, 5'd31, 16'd0, 5'd0);
    send_beat(OP_ARRIVE, 5'd31, 16'd0, 5'd0);        // already ready
    send_beat(OP_ARRIVE, 5'd0, 16'd0, 5'd0);
    tick();
    send_beat(OP_ARRIVE, 5'd0, 16'd0, 5'd0);         // running job arrives
    send_beat(OP_LOAD, 5'd0, 16'd2, 5'd0);           // reload of running job
    tick();
    send_beat(OP_ARRIVE, 5'd6, 16'd0, 5'd0);
    send_beat(OP_ARRIVE, 5'd5, 16'd0, 5'd0);
    repeat (8) tick();
  endtask

  task automatic test_random(input int n);
    int op_roll;
    for (int i = 0; i < n; i++) begin
      op_roll = $urandom_range(0, 99);
      if (op_roll < 15)
        send_beat(OP_LOAD, 5'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 12)),
                  5'($urandom));
      else if (op_roll < 25)
        send_beat(OP_DEP, 5'($urandom), 16'($urandom), 5'($urandom));
      else if (op_roll < 45)
        send_beat(OP_ARRIVE, 5'($urandom), 16'($urandom), 5'($urandom));
      else tick();
    end
  endtask

  // Receiver holds off while ticks keep coming, so the block backs up its input.
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (8) tick();
    wait (hold_cycles == 0);
  endtask

  initial begin
    for (int k = 0; k < NJOBS; k++) begin
      rem_q[k] = '0;
      deps_q[k] = '0;
    end
    started_q = '0;
    ready_q = '0;
    cur_q = '0;
    busy_q = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1000);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random(300);
    go_idle();
    fork
      wait (expected_ticks.size() == 0);
      repeat (200000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
